@@ design/adcsss_pkg.sv @@
// Shared types, register codes and rounding helpers for the A/D conditioning block.
package adcsss_pkg;

    localparam int NUM_COEF = 6;
    localparam int COEF_IW  = 3;
    localparam int CFG_IW   = 4;
    localparam int ACC_W    = 56;

    localparam logic [CFG_IW-1:0] REG_GAIN  = 4'd0;
    localparam logic [CFG_IW-1:0] REG_SKEW  = 4'd1;
    localparam logic [CFG_IW-1:0] REG_COEF0 = 4'd2;

    localparam logic signed [31:0] GAIN_RESET        = 32'sd16777216;
    localparam logic signed [17:0] COEF_CENTRE_RESET = 18'sd65536;

    typedef logic signed [17:0] coef_t;

    typedef struct packed {
        logic signed [15:0] raw_sample;
        logic               end_of_record;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] conditioned_value;
        logic               was_smoothed;
        logic               last_result;
    } result_t;

    typedef struct packed {
        logic signed [31:0]          gain;
        logic [15:0]                 skew_factor;
        coef_t [NUM_COEF-1:0]        coef;
    } cfg_t;

    // Clamp a 41-bit shifted value to signed 32 bits.
    function automatic logic signed [31:0] sat41(input logic signed [40:0] s);
        logic signed [31:0] r;
        if (s > 41'sd2147483647)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (s < -41'sd2147483648)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = s[31:0];
        end
        return r;
    endfunction

    // Q8.24 gain product down to Q16.16, round half up.
    function automatic logic signed [31:0] round_sat_gain(input logic signed [63:0] p);
        logic signed [64:0] t;
        logic signed [40:0] s;
        t = $signed({p[63], p}) + 65'sd8388608;
        s = t[64:24];
        return sat41(s);
    endfunction

    // Smoothing sum (Q2.16 taps) down to Q16.16, round half up.
    function automatic logic signed [31:0] round_sat_fir(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W:0] t;
        logic signed [40:0]    s;
        t = $signed({a[ACC_W-1], a}) + (ACC_W+1)'(32768);
        s = t[56:16];
        return sat41(s);
    endfunction

endpackage

@@ design/adcsss_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module adcsss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 13
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/adcsss_regs.sv @@
// Configuration register file: gain, skew fraction and smoothing coefficients.
module adcsss_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [adcsss_pkg::CFG_IW-1:0]  index,
    input  logic [31:0]                    data,
    output adcsss_pkg::cfg_t               cfg
);

    localparam int CIW = adcsss_pkg::COEF_IW;

    adcsss_pkg::cfg_t              cfg_reg;
    adcsss_pkg::cfg_t              cfg_next;
    logic [adcsss_pkg::CFG_IW-1:0] coef_off;
    logic [CIW-1:0]                coef_idx;

    assign coef_off = index - adcsss_pkg::REG_COEF0;
    assign coef_idx = coef_off[CIW-1:0];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            priority if (index == adcsss_pkg::REG_GAIN)
            begin
                cfg_next.gain = data;
            end
            else if (index == adcsss_pkg::REG_SKEW)
            begin
                cfg_next.skew_factor = data[15:0];
            end
            else if (index >= adcsss_pkg::REG_COEF0 &&
                     coef_off < adcsss_pkg::CFG_IW'(adcsss_pkg::NUM_COEF))
            begin
                cfg_next.coef[coef_idx] = data[17:0];
            end
            else
            begin
                // index beyond the list: drop the write
                cfg_next = cfg_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain        <= adcsss_pkg::GAIN_RESET;
            cfg_reg.skew_factor <= '0;
            cfg_reg.coef        <= {{(adcsss_pkg::NUM_COEF - 1){18'd0}},
                                    adcsss_pkg::COEF_CENTRE_RESET};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/adcsss_front.sv @@
// Front pipeline: zero-code repair, skew mix, gain multiply, rounding to Q16.16.
module adcsss_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [15:0] raw_sample,
    input  logic               first,
    input  logic signed [15:0] prev_raw,
    input  logic [15:0]        skew,
    input  logic signed [31:0] gain,
    output logic               done,
    output logic signed [15:0] raw_fix,
    output logic signed [31:0] value
);

    logic               v1_reg;
    logic               v2_reg;
    logic               v3_reg;
    logic signed [15:0] raw_fix_reg;
    logic signed [16:0] diff_reg;
    logic signed [31:0] mix_reg;
    logic signed [63:0] prod_reg;

    logic signed [15:0] prev_sel;
    logic signed [15:0] raw_sel;
    logic signed [16:0] diff_next;
    logic signed [33:0] base;
    logic signed [33:0] skew_prod;
    logic signed [33:0] mix_full;

    // A zero code after the first sample repeats the previous code.
    assign prev_sel  = first ? raw_sample : prev_raw;
    assign raw_sel   = (!first && raw_sample == 16'sd0) ? prev_raw : raw_sample;
    assign diff_next = $signed({prev_sel[15], prev_sel}) - $signed({raw_sel[15], raw_sel});

    // mix = 65536*r + skew*(prev - r); the weights sum to 65536 so it fits 32 bits.
    assign base      = {{2{raw_fix_reg[15]}}, raw_fix_reg, 16'h0000};
    assign skew_prod = $signed({1'b0, skew}) * diff_reg;
    assign mix_full  = base + skew_prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            raw_fix_reg <= raw_sel;
            diff_reg    <= diff_next;
        end
        if (v1_reg)
        begin
            mix_reg <= mix_full[31:0];
        end
        if (v2_reg)
        begin
            prod_reg <= mix_reg * gain;
        end
    end

    assign done    = v3_reg;
    assign raw_fix = raw_fix_reg;
    assign value   = adcsss_pkg::round_sat_gain(prod_reg);

endmodule

@@ design/adcsss_mac.sv @@
// Shared multiply-accumulate for the symmetric smoother: pre-add, multiply, accumulate.
module adcsss_mac (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  logic                in_valid,
    input  logic                center,
    input  logic signed [31:0]  a,
    input  logic signed [31:0]  b,
    input  adcsss_pkg::coef_t   coef,
    output logic                busy,
    output logic signed [31:0]  value
);

    localparam int AW = adcsss_pkg::ACC_W;

    logic                 v1_reg;
    logic                 v2_reg;
    logic signed [32:0]   pair_reg;
    adcsss_pkg::coef_t    coef_reg;
    logic signed [50:0]   prod_reg;
    logic signed [AW-1:0] acc_reg;

    logic signed [32:0]   pair_next;

    // The centre tap has no mirror partner.
    assign pair_next = center ? $signed({a[31], a})
                              : $signed({a[31], a}) + $signed({b[31], b});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            pair_reg <= pair_next;
            coef_reg <= coef;
        end
        if (v1_reg)
        begin
            prod_reg <= pair_reg * coef_reg;
        end
        if (clear)
        begin
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg + AW'(prod_reg);
        end
    end

    assign busy  = v1_reg | v2_reg;
    assign value = adcsss_pkg::round_sat_fir(acc_reg);

endmodule

@@ design/adc_scale_skew_smooth_top.sv @@
// Top level: sample window memory, per-sample sequencer and output register.
//
// Conditions one A/D channel. Each transfer on the sample channel carries one
// raw code and an end-of-record flag; the block repairs, deskews, scales to
// Q16.16 and stores the value in a circular window of 2*HALF_TAPS+1 entries
// held in two RAM copies (two reads per cycle). Results leave on the result
// channel HALF_TAPS+1 samples late; middle samples of a record are smoothed.
// The flagged last sample flushes the remaining samples, the final one with
// last_result set. Registers are to be written on the cfg channel only between
// records; the block does not enforce this. One sample is in work at a time.
// A smoothed result takes the centre tap and then NK = min(HALF_TAPS-1, 5)
// mirrored tap pairs, fed one pair a cycle through the single shared
// multiply-accumulate. Each flushed result takes one window read and one load
// of the output register.
// Reset clears control state and restores register defaults; window contents
// are undefined but never read before being written in a record.
// A stalled receiver holds the result register; the block holds the current
// sample's result until the register frees and takes no new sample meanwhile.
module adc_scale_skew_smooth_top #(
    parameter int HALF_TAPS = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  adcsss_pkg::sample_t           sample,
    output logic                          result_valid,
    input  logic                          result_ready,
    output adcsss_pkg::result_t           result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [adcsss_pkg::CFG_IW-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);

    localparam int W        = 2 * HALF_TAPS + 1;
    localparam int AW       = $clog2(W);
    localparam int SEEN_MAX = 2 * HALF_TAPS + 2;
    localparam int SW       = $clog2(SEEN_MAX + 1);
    localparam int CIDX     = HALF_TAPS + 1;
    localparam int NK       = (HALF_TAPS - 1 < adcsss_pkg::NUM_COEF - 1) ?
                              HALF_TAPS - 1 : adcsss_pkg::NUM_COEF - 1;
    localparam int KW       = $clog2(NK + 1);
    localparam int FW       = $clog2(HALF_TAPS + 2);
    localparam int CIW      = adcsss_pkg::COEF_IW;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FRONT = 3'd1;
    localparam logic [2:0] S_FIR   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    // window[i] (i = 0 newest) sits i entries behind the write pointer
    function automatic logic [AW-1:0] win_addr(input logic [AW-1:0] p,
                                               input logic [AW-1:0] i);
        logic [AW:0] t;
        if (p >= i)
        begin
            t = {1'b0, p} - {1'b0, i};
        end
        else
        begin
            t = {1'b0, p} + (AW+1)'(W) - {1'b0, i};
        end
        return t[AW-1:0];
    endfunction

    adcsss_pkg::cfg_t    cfg;

    logic [2:0]          state_reg,     state_next;
    logic [AW-1:0]       ptr_reg,       ptr_next;
    logic [SW-1:0]       seen_reg,      seen_next;
    logic signed [15:0]  prev_raw_reg,  prev_raw_next;
    logic                eor_reg,       eor_next;
    logic                flushing_reg,  flushing_next;
    logic                emit_fir_reg,  emit_fir_next;
    logic [FW-1:0]       fl_idx_reg,    fl_idx_next;
    logic [KW-1:0]       k_reg,         k_next;
    logic                fir_rd_reg;
    logic [KW-1:0]       k_d_reg;
    logic                result_valid_reg, result_valid_next;
    adcsss_pkg::result_t result_reg;

    logic                accept;
    logic                front_done;
    logic signed [15:0]  front_raw_fix;
    logic signed [31:0]  front_value;
    logic [AW-1:0]       ptr_inc;
    logic [SW-1:0]       seen_inc;
    logic                ram_we;
    logic                rd_en_a;
    logic                rd_en_b;
    logic [AW-1:0]       rd_addr_a;
    logic [AW-1:0]       rd_addr_b;
    logic [31:0]         rd_data_a;
    logic [31:0]         rd_data_b;
    logic                mac_clear;
    logic                mac_busy;
    logic signed [31:0]  mac_value;
    logic [CIW-1:0]      coef_idx;
    logic                out_free;
    logic                out_load;

    assign accept    = sample_valid && sample_ready;
    assign cfg_ready = 1'b1;
    assign ptr_inc   = (ptr_reg == AW'(W - 1)) ? '0 : ptr_reg + 1'b1;
    assign seen_inc  = (seen_reg == SW'(SEEN_MAX)) ? seen_reg : seen_reg + 1'b1;
    assign out_free  = !result_valid_reg || result_ready;
    assign coef_idx  = CIW'(k_d_reg);

    adcsss_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (cfg_valid && cfg_ready),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    adcsss_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept),
        .raw_sample (sample.raw_sample),
        .first      (seen_reg == '0),
        .prev_raw   (prev_raw_reg),
        .skew       (cfg.skew_factor),
        .gain       (cfg.gain),
        .done       (front_done),
        .raw_fix    (front_raw_fix),
        .value      (front_value)
    );

    adcsss_ram #(.WIDTH(32), .DEPTH(W)) u_win_a (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ptr_inc),
        .wr_data (front_value),
        .rd_en   (rd_en_a),
        .rd_addr (rd_addr_a),
        .rd_data (rd_data_a)
    );

    adcsss_ram #(.WIDTH(32), .DEPTH(W)) u_win_b (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ptr_inc),
        .wr_data (front_value),
        .rd_en   (rd_en_b),
        .rd_addr (rd_addr_b),
        .rd_data (rd_data_b)
    );

    adcsss_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (mac_clear),
        .in_valid (fir_rd_reg),
        .center   (k_d_reg == '0),
        .a        (rd_data_a),
        .b        (rd_data_b),
        .coef     (cfg.coef[coef_idx]),
        .busy     (mac_busy),
        .value    (mac_value)
    );

    always_comb
    begin
        state_next        = state_reg;
        ptr_next          = ptr_reg;
        seen_next         = seen_reg;
        prev_raw_next     = prev_raw_reg;
        eor_next          = eor_reg;
        flushing_next     = flushing_reg;
        emit_fir_next     = emit_fir_reg;
        fl_idx_next       = fl_idx_reg;
        k_next            = k_reg;
        ram_we            = 1'b0;
        rd_en_a           = 1'b0;
        rd_en_b           = 1'b0;
        rd_addr_a         = win_addr(ptr_reg, AW'(CIDX));
        rd_addr_b         = win_addr(ptr_reg, AW'(CIDX));
        mac_clear         = 1'b0;
        out_load          = 1'b0;
        result_valid_next = result_valid_reg && !result_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    eor_next   = sample.end_of_record;
                    state_next = S_FRONT;
                end
            end
            S_FRONT:
            begin
                if (front_done)
                begin
                    ram_we        = 1'b1;
                    ptr_next      = ptr_inc;
                    seen_next     = seen_inc;
                    prev_raw_next = eor_reg ? 16'sd0 : front_raw_fix;
                    fl_idx_next   = (seen_inc > SW'(HALF_TAPS + 1)) ?
                                    FW'(HALF_TAPS + 1) : FW'(seen_inc);
                    flushing_next = 1'b0;
                    emit_fir_next = 1'b0;
                    if (seen_inc >= SW'(HALF_TAPS + 2))
                    begin
                        if (seen_inc == SW'(SEEN_MAX))
                        begin
                            k_next        = '0;
                            mac_clear     = 1'b1;
                            emit_fir_next = 1'b1;
                            state_next    = S_FIR;
                        end
                        else
                        begin
                            state_next = S_RD;
                        end
                    end
                    else if (eor_reg)
                    begin
                        flushing_next = 1'b1;
                        state_next    = S_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FIR:
            begin
                // one mirrored pair per cycle, centre first
                rd_en_a   = 1'b1;
                rd_en_b   = 1'b1;
                rd_addr_a = win_addr(ptr_reg, AW'(CIDX) - AW'(k_reg));
                rd_addr_b = win_addr(ptr_reg, AW'(CIDX) + AW'(k_reg));
                if (k_reg == KW'(NK))
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (!fir_rd_reg && !mac_busy)
                begin
                    state_next = S_EMIT;
                end
            end
            S_RD:
            begin
                rd_en_a    = 1'b1;
                rd_addr_a  = flushing_reg ? win_addr(ptr_reg, AW'(fl_idx_reg - 1'b1))
                                          : win_addr(ptr_reg, AW'(CIDX));
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // hold the read data until the result register frees up
                if (out_free)
                begin
                    out_load          = 1'b1;
                    result_valid_next = 1'b1;
                    emit_fir_next     = 1'b0;
                    if (flushing_reg)
                    begin
                        if (fl_idx_reg == FW'(1))
                        begin
                            seen_next     = '0;
                            flushing_next = 1'b0;
                            state_next    = S_IDLE;
                        end
                        else
                        begin
                            fl_idx_next = fl_idx_reg - 1'b1;
                            state_next  = S_RD;
                        end
                    end
                    else if (eor_reg)
                    begin
                        flushing_next = 1'b1;
                        state_next    = S_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            ptr_reg          <= '0;
            seen_reg         <= '0;
            prev_raw_reg     <= '0;
            eor_reg          <= 1'b0;
            flushing_reg     <= 1'b0;
            emit_fir_reg     <= 1'b0;
            fl_idx_reg       <= '0;
            k_reg            <= '0;
            fir_rd_reg       <= 1'b0;
            k_d_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            ptr_reg          <= ptr_next;
            seen_reg         <= seen_next;
            prev_raw_reg     <= prev_raw_next;
            eor_reg          <= eor_next;
            flushing_reg     <= flushing_next;
            emit_fir_reg     <= emit_fir_next;
            fl_idx_reg       <= fl_idx_next;
            k_reg            <= k_next;
            fir_rd_reg       <= (state_reg == S_FIR);
            k_d_reg          <= k_reg;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result_reg.conditioned_value <= emit_fir_reg ? mac_value : rd_data_a;
            result_reg.was_smoothed      <= emit_fir_reg;
            result_reg.last_result       <= flushing_reg && (fl_idx_reg == FW'(1));
        end
    end

    assign sample_ready = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_front_in_front: assert property (@(posedge clk) disable iff (!rst_n)
        front_done |-> state_reg == S_FRONT)
        else $error("front pipeline finished outside its wait state");

    a_mac_in_fir: assert property (@(posedge clk) disable iff (!rst_n)
        mac_busy |-> (state_reg == S_FIR || state_reg == S_DRAIN))
        else $error("smoother pipeline active outside the smoothing states");

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= SW'(SEEN_MAX))
        else $error("sample count past its saturation value");

    a_smooth_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.was_smoothed && result.last_result))
        else $error("smoothed result flagged as last of record");

endmodule

@@ verif/adc_scale_skew_smooth_tb.sv @@
// Testbench for the A/D conditioning block: repair, deskew, gain and symmetric smoothing.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_TAPS = 6;
    localparam int WIN_LEN = 2 * HALF_TAPS + 1;
    localparam int SEEN_MAX = 2 * HALF_TAPS + 2;
    localparam int CLK_HALF = 10;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_PER_PHASE = 100;
    localparam int TIMEOUT_NS = 5_000_000;

    localparam logic [31:0] GAIN_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] GAIN_MIN = 32'h8000_0000;
    localparam logic [31:0] SKEW_MAX = 32'h0000_FFFF;
    localparam logic [31:0] COEF_MAX = 32'h0001_FFFF;
    localparam logic [31:0] COEF_MIN = 32'h0002_0000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sample_valid = 1'b0;
    logic sample_ready;
    adcsss_pkg::sample_t sample = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    adcsss_pkg::result_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [adcsss_pkg::CFG_IW-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int mismatch_count = 0;

    // Mirror of the block state and registers
    logic signed [31:0] gain_q = adcsss_pkg::GAIN_RESET;
    logic [15:0] skew_q = '0;
    adcsss_pkg::coef_t taps [adcsss_pkg::NUM_COEF];
    logic signed [15:0] last_code = '0;
    logic signed [31:0] history [WIN_LEN];
    int rec_count = 0;

    adcsss_pkg::result_t pending_results [$];
    adcsss_pkg::result_t want_result;

    adc_scale_skew_smooth_top #(
        .HALF_TAPS(HALF_TAPS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .sample_valid(sample_valid),
        .sample_ready(sample_ready),
        .sample(sample),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #(CLK_HALF);
        clk = 1'b0;
        #(CLK_HALF);
    end

    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %0d/%0b/%0b", $time,
                         result.conditioned_value, result.was_smoothed, result.last_result);
                mismatch_count++;
            end
            else
            begin
                want_result = pending_results.pop_front();
                if (result.conditioned_value !== want_result.conditioned_value)
                begin
                    $display("%0t: conditioned_value expected %0d actual %0d", $time,
                             want_result.conditioned_value, result.conditioned_value);
                    mismatch_count++;
                end
                if (result.was_smoothed !== want_result.was_smoothed)
                begin
                    $display("%0t: was_smoothed expected %0b actual %0b", $time,
                             want_result.was_smoothed, result.was_smoothed);
                    mismatch_count++;
                end
                if (result.last_result !== want_result.last_result)
                begin
                    $display("%0t: last_result expected %0b actual %0b", $time,
                             want_result.last_result, result.last_result);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Add half an LSB, then floor
    function automatic longint round_down(input longint v, input int sh);
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic longint tap_weight(input int k);
        if (k >= adcsss_pkg::NUM_COEF)
        begin
            return longint'(0);
        end
        return longint'(taps[k]);
    endfunction

    function automatic logic signed [31:0] smoothed_value();
        int centre;
        int k;
        longint acc;
        centre = HALF_TAPS + 1;
        acc = tap_weight(0) * longint'(history[centre]);
        for (k = 1; k < HALF_TAPS; k++)
        begin
            acc += tap_weight(k) * (longint'(history[centre + k]) +
                                    longint'(history[centre - k]));
        end
        return clamp32(round_down(acc, 16));
    endfunction

    // Advance the mirrored state by one sample and queue the results it releases
    function automatic void condition_sample(input adcsss_pkg::sample_t s);
        longint code;
        longint prior;
        longint skew;
        longint mix;
        adcsss_pkg::result_t r;
        int i;
        int cnt;
        code = longint'(s.raw_sample);
        if (rec_count > 0)
        begin
            prior = longint'(last_code);
            if (code == 0)
            begin
                code = prior;
            end
        end
        else
        begin
            prior = code;
        end
        skew = longint'(skew_q);
        mix = (64'sd65536 - skew) * code + skew * prior;
        last_code = code[15:0];
        for (i = WIN_LEN - 1; i > 0; i--)
        begin
            history[i] = history[i - 1];
        end
        history[0] = clamp32(round_down(mix * longint'(gain_q), 24));
        if (rec_count < SEEN_MAX)
        begin
            rec_count++;
        end
        if (rec_count >= HALF_TAPS + 2)
        begin
            r.was_smoothed = (rec_count >= SEEN_MAX);
            r.conditioned_value = r.was_smoothed ? smoothed_value() : history[HALF_TAPS + 1];
            r.last_result = 1'b0;
            pending_results.push_back(r);
        end
        if (s.end_of_record)
        begin
            cnt = (rec_count < HALF_TAPS + 1) ? rec_count : HALF_TAPS + 1;
            for (i = cnt; i > 0; i--)
            begin
                r.conditioned_value = history[i - 1];
                r.was_smoothed = 1'b0;
                r.last_result = (i == 1);
                pending_results.push_back(r);
            end
            rec_count = 0;
            last_code = '0;
        end
    endfunction

    task automatic send_sample(input logic signed [15:0] code, input logic eor);
        adcsss_pkg::sample_t item;
        item.raw_sample = code;
        item.end_of_record = eor;
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= item;
        do
            @(posedge clk);
        while (!sample_ready);
        condition_sample(item);
    endtask

    task automatic wait_for_results();
        sample_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // Let a sample that makes no result finish before touching registers
    task automatic settle_block();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [adcsss_pkg::CFG_IW-1:0] idx,
                             input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == adcsss_pkg::REG_GAIN)
        begin
            gain_q = data;
        end
        else if (idx == adcsss_pkg::REG_SKEW)
        begin
            skew_q = data[15:0];
        end
        else if (idx >= adcsss_pkg::REG_COEF0 &&
                 idx < adcsss_pkg::REG_COEF0 + adcsss_pkg::NUM_COEF)
        begin
            taps[adcsss_pkg::COEF_IW'(idx - adcsss_pkg::REG_COEF0)] = data[17:0];
        end
    endtask

    task automatic write_settings(input logic [31:0] gain_word, input logic [31:0] skew_word,
                                  input logic [31:0] coef_words [adcsss_pkg::NUM_COEF]);
        int k;
        write_reg(adcsss_pkg::REG_GAIN, gain_word);
        write_reg(adcsss_pkg::REG_SKEW, skew_word);
        for (k = 0; k < adcsss_pkg::NUM_COEF; k++)
        begin
            write_reg(adcsss_pkg::CFG_IW'(adcsss_pkg::REG_COEF0 + k), coef_words[k]);
        end
        // Index past the register list must be dropped
        write_reg(adcsss_pkg::CFG_IW'($urandom_range(adcsss_pkg::REG_COEF0 +
                                                     adcsss_pkg::NUM_COEF,
                                                     (1 << adcsss_pkg::CFG_IW) - 1)),
                  $urandom());
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] random_coef();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
        begin
            return COEF_MAX;
        end
        if (pick == 1)
        begin
            return COEF_MIN;
        end
        if (pick < 7)
        begin
            return {14'($urandom_range(0, 16383)),
                    18'(int'($urandom_range(0, 32768)) - 16384)};
        end
        return $urandom();
    endfunction

    task automatic randomize_settings();
        logic [31:0] gain_word;
        logic [31:0] skew_word;
        logic [31:0] coef_words [adcsss_pkg::NUM_COEF];
        int pick;
        int k;
        pick = $urandom_range(9);
        if (pick == 0)
        begin
            gain_word = GAIN_MAX;
        end
        else if (pick == 1)
        begin
            gain_word = GAIN_MIN;
        end
        else if (pick < 7)
        begin
            gain_word = int'($urandom_range(0, 1 << 26)) - (1 << 25);
        end
        else
        begin
            gain_word = $urandom();
        end
        pick = $urandom_range(9);
        skew_word = {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))};
        if (pick == 0)
        begin
            skew_word[15:0] = '0;
        end
        else if (pick == 1)
        begin
            skew_word[15:0] = '1;
        end
        for (k = 0; k < adcsss_pkg::NUM_COEF; k++)
        begin
            coef_words[k] = random_coef();
        end
        write_settings(gain_word, skew_word, coef_words);
    endtask

    function automatic logic signed [15:0] random_code();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            return '0;
        end
        if (pick < 13)
        begin
            return 16'sh7FFF;
        end
        if (pick < 16)
        begin
            return 16'sh8000;
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic send_record(input int len);
        int n;
        for (n = 1; n <= len; n++)
        begin
            if ($urandom_range(60) == 0)
            begin
                wait_for_results();
            end
            send_sample(random_code(), n == len);
        end
    endtask

    // Zero first code, zero repeat, code extremes, one-sample record, default registers
    task automatic test_first_samples();
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd5, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(-16'sd32768, 1'b1);
        send_sample(16'sd32767, 1'b1);
        wait_for_results();
    endtask

    // Full record with smoothed middle, tap extremes, maximum skew and a seven-result flush
    task automatic test_long_record();
        logic signed [15:0] codes [15] = '{16'sd100, -16'sd200, 16'sd0, 16'sd32767,
                                           -16'sd32768, 16'sd7, 16'sd0, 16'sd12345,
                                           -16'sd1, 16'sd1, 16'sd0, -16'sd30000,
                                           16'sd30000, 16'sd4096, -16'sd4096};
        logic [31:0] coef_words [adcsss_pkg::NUM_COEF] = '{COEF_MAX, COEF_MIN, COEF_MAX,
                                                          COEF_MIN, COEF_MAX, COEF_MIN};
        int n;
        settle_block();
        write_settings(32'h0001_0000, SKEW_MAX, coef_words);
        for (n = 0; n < 15; n++)
        begin
            // Hold the sender mid-record until the block has emptied
            if (n == 9)
            begin
                wait_for_results();
            end
            send_sample(codes[n], n == 14);
        end
        wait_for_results();
    endtask

    // Gain saturation in both directions
    task automatic test_gain_extremes();
        logic [31:0] coef_words [adcsss_pkg::NUM_COEF] = '{COEF_MIN, COEF_MAX, COEF_MIN,
                                                          COEF_MAX, COEF_MIN, COEF_MAX};
        settle_block();
        write_settings(GAIN_MAX, 32'h0000_0000, coef_words);
        send_sample(16'sd32767, 1'b0);
        send_sample(-16'sd32768, 1'b1);
        settle_block();
        write_settings(GAIN_MIN, 32'h0000_8000, coef_words);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd1, 1'b1);
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        int phase;
        int count;
        int len;
        int pick;
        for (phase = 0; phase < 4; phase++)
        begin
            settle_block();
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 87; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 87; end
                default: begin send_idle_pct = 13; stall_pct = 13; end
            endcase
            randomize_settings();
            count = 0;
            while (count < RANDOM_PER_PHASE)
            begin
                pick = $urandom_range(9);
                if (pick == 0)
                begin
                    len = $urandom_range(1, HALF_TAPS + 1);
                end
                else if (pick == 1)
                begin
                    len = $urandom_range(SEEN_MAX - 1, SEEN_MAX);
                end
                else
                begin
                    len = $urandom_range(HALF_TAPS + 2, 40);
                end
                send_record(len);
                count += len;
            end
        end
    endtask

    initial
    begin
        taps[0] = adcsss_pkg::COEF_CENTRE_RESET;
        for (int k = 1; k < adcsss_pkg::NUM_COEF; k++)
        begin
            taps[k] = '0;
        end
        for (int k = 0; k < WIN_LEN; k++)
        begin
            history[k] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_first_samples();
        test_long_record();
        test_gain_extremes();
        test_random_traffic();
        settle_block();
        if (mismatch_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule
